// ===== rtl/core/ewpa_pkg.sv =====
// shared types, constants and register codes of the power allocation block
package ewpa_pkg;

   localparam int unsigned MOTOR_COUNT = 4;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned TOTAL_W = 34;
   localparam int unsigned RESERVE_W = 30;
   localparam int unsigned ALPHA_W = 16;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned DIV_STEPS = 32;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_COMP_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMP_ALPHA = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMALL_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVE_BORDER = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVE_PER_MOTOR = 3'd4;

   // how the limits of one item are formed
   typedef enum logic [1:0] {
      MODE_ZERO    = 2'd0,
      MODE_EQUAL   = 2'd1,
      MODE_PROP    = 2'd2,
      MODE_RESERVE = 2'd3
   } mode_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic                 comp_enable;
      logic [ALPHA_W-1:0]   comp_alpha;
      logic [WORD_W-1:0]    small_error_threshold;
      logic [WORD_W-1:0]    reserve_border;
      logic [RESERVE_W-1:0] reserve_per_motor;
   } cfg_type;

   // one item inside the divider pipeline
   typedef struct packed {
      mode_type                                mode;
      logic [WORD_W-3:0]                       quarter;
      logic [TOTAL_W-1:0]                      divisor;
      logic [MOTOR_COUNT-1:0][TOTAL_W-1:0]     rem;
      logic [MOTOR_COUNT-1:0][WORD_W-1:0]      acc;
   } div_item_type;

endpackage

// ===== rtl/core/ewpa_front.sv =====
// front stages: absolute errors and budget, error sum and rest, mode and products
module ewpa_front (
   input  logic                  clock,
   input  logic                  reset,
   input  ewpa_pkg::cfg_type     cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [ewpa_pkg::MOTOR_COUNT-1:0][ewpa_pkg::WORD_W-1:0] in_error,
   input  logic [ewpa_pkg::WORD_W-1:0] in_budget,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ewpa_pkg::div_item_type out_item
);
   import ewpa_pkg::*;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   logic [MOTOR_COUNT-1:0][WORD_W-1:0] s1_abs_ff, s1_abs_in;
   logic [WORD_W-1:0]                  s1_budget_ff, s1_budget_in;
   logic [MOTOR_COUNT-1:0][WORD_W-1:0] s2_abs_ff;
   logic [WORD_W-1:0]                  s2_budget_ff;
   logic [TOTAL_W-1:0]                 s2_total_ff, s2_total_in;
   logic [WORD_W-1:0]                  s2_rest_ff, s2_rest_in;
   div_item_type                       s3_item_ff, s3_item_in;

   logic [ALPHA_W:0]          keep_frac;
   logic [WORD_W+ALPHA_W:0]   comp_prod;
   logic [WORD_W-1:0]         res4;
   mode_type                  mode;
   logic [WORD_W-1:0]         mult;
   logic [2*WORD_W-1:0]       prod [MOTOR_COUNT];

   // stall chain, a stage moves when the next one is free
   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1: absolute errors and compensated budget
   always_comb begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         s1_abs_in[i] = in_error[i][WORD_W-1] ? (~in_error[i] + WORD_W'(1)) : in_error[i];
      end
      keep_frac = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, cfg.comp_alpha};
      comp_prod = (WORD_W+ALPHA_W+1)'(in_budget) * (WORD_W+ALPHA_W+1)'(keep_frac);
      s1_budget_in = cfg.comp_enable ? comp_prod[WORD_W+ALPHA_W-1:ALPHA_W] : in_budget;
   end

   // stage 2: error sum and budget left after the reserve
   always_comb begin
      s2_total_in = '0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         s2_total_in = s2_total_in + {{(TOTAL_W-WORD_W){1'b0}}, s1_abs_ff[i]};
      end
      res4 = {cfg.reserve_per_motor, 2'b00};
      s2_rest_in = (s1_budget_ff > res4) ? (s1_budget_ff - res4) : '0;
   end

   // stage 3: case decision and error products
   always_comb begin
      priority if (s2_budget_ff == '0) begin
         mode = MODE_ZERO;
      end else if (s2_total_ff <= {{(TOTAL_W-WORD_W){1'b0}}, cfg.small_error_threshold}) begin
         mode = MODE_EQUAL;
      end else if (s2_budget_ff < cfg.reserve_border) begin
         mode = MODE_PROP;
      end else begin
         mode = MODE_RESERVE;
      end
      mult = (mode == MODE_PROP) ? s2_budget_ff : s2_rest_ff;
      s3_item_in.mode = mode;
      s3_item_in.quarter = s2_budget_ff[WORD_W-1:2];
      s3_item_in.divisor = s2_total_ff;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         prod[i] = (2*WORD_W)'(s2_abs_ff[i]) * (2*WORD_W)'(mult);
         s3_item_in.rem[i] = {{(TOTAL_W-WORD_W){1'b0}}, prod[i][2*WORD_W-1:WORD_W]};
         s3_item_in.acc[i] = prod[i][WORD_W-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_abs_ff <= s1_abs_in;
         s1_budget_ff <= s1_budget_in;
      end
      if (s2_ready) begin
         s2_abs_ff <= s1_abs_ff;
         s2_budget_ff <= s1_budget_ff;
         s2_total_ff <= s2_total_in;
         s2_rest_ff <= s2_rest_in;
      end
      if (s3_ready) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item = s3_item_ff;

endmodule

// ===== rtl/core/ewpa_div_stage.sv =====
// one restoring division step for all four motor lanes
module ewpa_div_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ewpa_pkg::div_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ewpa_pkg::div_item_type out_item
);
   import ewpa_pkg::*;

   logic         valid_ff;
   div_item_type item_ff, item_in;
   logic [TOTAL_W:0] trial [MOTOR_COUNT];
   logic         ge [MOTOR_COUNT];

   assign in_ready = !valid_ff || out_ready;

   // shift in the next numerator bit, subtract the divisor where it fits
   always_comb begin
      item_in = in_item;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         trial[i] = {in_item.rem[i], in_item.acc[i][WORD_W-1]};
         ge[i] = trial[i] >= {1'b0, in_item.divisor};
         item_in.rem[i] = ge[i] ? TOTAL_W'(trial[i] - {1'b0, in_item.divisor})
                                : trial[i][TOTAL_W-1:0];
         item_in.acc[i] = {in_item.acc[i][WORD_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule

// ===== rtl/core/error_weighted_power_allocation.sv =====
// path from input transfer to result: 3 front stages, 32 divider steps, output register
// throughput: one item per cycle while no stall holds the chain; each divider step resolves one quotient bit per lane
// ready passes back combinationally through all stages, so bubbles fill while a result waits
// reset clears all valid bits and loads the register reset values
// synchronous active-high reset, no clearing pass
module error_weighted_power_allocation (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wen,
   input  logic [ewpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ewpa_pkg::WORD_W-1:0]      csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // error_a, error_b, error_c, error_d, power_budget
   input  logic [159:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // limit_a, limit_b, limit_c, limit_d
   output logic [127:0]  rsp_tdata
);
   import ewpa_pkg::*;

   cfg_type cfg_ff;
   logic [MOTOR_COUNT-1:0][WORD_W-1:0] req_error;
   logic [WORD_W-1:0] req_budget;

   logic         stg_valid [DIV_STEPS+1];
   logic         stg_ready [DIV_STEPS+1];
   div_item_type stg_item  [DIV_STEPS+1];

   logic         out_valid_ff;
   mode_type     out_mode_ff;
   logic [MOTOR_COUNT-1:0][WORD_W-1:0] limit_ff, limit_in;
   logic         out_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.comp_enable <= 1'b0;
         cfg_ff.comp_alpha <= '0;
         cfg_ff.small_error_threshold <= '0;
         cfg_ff.reserve_border <= '1;
         cfg_ff.reserve_per_motor <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_COMP_ENABLE:       cfg_ff.comp_enable <= csr_wdata[0];
            CSR_COMP_ALPHA:        cfg_ff.comp_alpha <= csr_wdata[ALPHA_W-1:0];
            CSR_SMALL_THRESHOLD:   cfg_ff.small_error_threshold <= csr_wdata;
            CSR_RESERVE_BORDER:    cfg_ff.reserve_border <= csr_wdata;
            CSR_RESERVE_PER_MOTOR: cfg_ff.reserve_per_motor <= csr_wdata[RESERVE_W-1:0];
            default: ;
         endcase
      end
   end

   // unpack the request
   always_comb begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         req_error[i] = req_tdata[i*WORD_W +: WORD_W];
      end
      req_budget = req_tdata[MOTOR_COUNT*WORD_W +: WORD_W];
   end

   ewpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_error  (req_error),
      .in_budget (req_budget),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_item  (stg_item[0])
   );

   // divider chain, one quotient bit per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      ewpa_div_stage u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_item   (stg_item[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_item  (stg_item[k+1])
      );
   end

   assign out_ready = !out_valid_ff || rsp_tready;
   assign stg_ready[DIV_STEPS] = out_ready;

   // final limit selection
   always_comb begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         unique case (stg_item[DIV_STEPS].mode)
            MODE_ZERO:  limit_in[i] = '0;
            MODE_EQUAL: limit_in[i] = {2'b00, stg_item[DIV_STEPS].quarter};
            MODE_PROP:  limit_in[i] = stg_item[DIV_STEPS].acc[i];
            default:    limit_in[i] = stg_item[DIV_STEPS].acc[i]
                                      + {{(WORD_W-RESERVE_W){1'b0}}, cfg_ff.reserve_per_motor};
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= stg_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         limit_ff <= limit_in;
         out_mode_ff <= stg_item[DIV_STEPS].mode;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = limit_ff;

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // equal split gives four identical limits
   a_equal_split: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_mode_ff == MODE_EQUAL) |->
      (limit_ff[0] == limit_ff[1] && limit_ff[1] == limit_ff[2] && limit_ff[2] == limit_ff[3]))
      else $error("equal split limits differ");

   // reserve split keeps limits a and d at or above the reserve
   a_reserve_floor: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_mode_ff == MODE_RESERVE) |->
      (limit_ff[0] >= {2'b00, cfg_ff.reserve_per_motor}
       && limit_ff[3] >= {2'b00, cfg_ff.reserve_per_motor}))
      else $error("reserve limit below reserve");

endmodule

// ===== test/error_weighted_power_allocation_check.sv =====
// checker for the power allocation block: watches both channels, predicts and compares limits
module error_weighted_power_allocation_check (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [159:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   output int           fail_count,
   output int           pending_count,
   output int           limit_count
);
   import ewpa_pkg::*;

   logic        comp_enable_q;
   logic [15:0] comp_alpha_q;
   logic [31:0] small_threshold_q;
   logic [31:0] reserve_border_q;
   logic [29:0] reserve_per_motor_q;

   logic [127:0] limits_expected[$];

   // split the budget across four motors: zero, equal split, or by error weight, with or without the reserve
   function automatic logic [127:0] allocate_limits(input logic [159:0] item);
      logic [63:0]  budget;
      logic [63:0]  total;
      logic [63:0]  mag[4];
      logic [63:0]  rest;
      logic [63:0]  res4;
      logic [127:0] limits;
      logic [31:0]  raw;
      budget = {32'd0, item[159:128]};
      total = 0;
      limits = '0;
      if (comp_enable_q)
         budget = (budget * (64'd65536 - comp_alpha_q)) >> 16;
      for (int m = 0; m < 4; m++) begin
         raw = item[32*m +: 32];
         mag[m] = raw[31] ? (64'h1_0000_0000 - raw) : {32'd0, raw};
         total += mag[m];
      end
      if (budget == 0) begin
         limits = '0;
      end else if (total <= small_threshold_q) begin
         for (int m = 0; m < 4; m++)
            limits[32*m +: 32] = budget[33:2];
      end else if (budget < reserve_border_q) begin
         for (int m = 0; m < 4; m++)
            limits[32*m +: 32] = mag[m] * budget / total;
      end else begin
         res4 = 64'(reserve_per_motor_q) * 4;
         rest = budget > res4 ? budget - res4 : 0;
         for (int m = 0; m < 4; m++)
            limits[32*m +: 32] = mag[m] * rest / total + reserve_per_motor_q;
      end
      return limits;
   endfunction

   assign pending_count = limits_expected.size();

   always @(posedge clock) begin
      logic [127:0] want;
      int           errs;
      errs = 0;
      if (reset) begin
         comp_enable_q <= 1'b0;
         comp_alpha_q <= '0;
         small_threshold_q <= '0;
         reserve_border_q <= '1;
         reserve_per_motor_q <= '0;
         fail_count <= 0;
         limit_count <= 0;
         limits_expected.delete();
      end else begin
         // register writes
         if (csr_wen) begin
            case (csr_index)
               CSR_COMP_ENABLE:       comp_enable_q <= csr_wdata[0];
               CSR_COMP_ALPHA:        comp_alpha_q <= csr_wdata[15:0];
               CSR_SMALL_THRESHOLD:   small_threshold_q <= csr_wdata;
               CSR_RESERVE_BORDER:    reserve_border_q <= csr_wdata;
               CSR_RESERVE_PER_MOTOR: reserve_per_motor_q <= csr_wdata[29:0];
               default: ;
            endcase
         end
         // input transfer
         if (req_tvalid && req_tready)
            limits_expected.push_back(allocate_limits(req_tdata));
         // result transfer
         if (rsp_tvalid && rsp_tready) begin
            limit_count <= limit_count + 1;
            if (limits_expected.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               errs = 1;
            end else begin
               want = limits_expected.pop_front();
               for (int m = 0; m < 4; m++) begin
                  if (want[32*m +: 32] !== rsp_tdata[32*m +: 32]) begin
                     $display("%0t: limit %0d expected %h actual %h", $time, m,
                              want[32*m +: 32], rsp_tdata[32*m +: 32]);
                     errs++;
                  end
               end
            end
            fail_count <= fail_count + errs;
         end
      end
   end

endmodule

// ===== test/error_weighted_power_allocation_test.sv =====
// testbench top: drives registers and error items into the allocation block, gives the verdict
module error_weighted_power_allocation_test;
   import ewpa_pkg::*;

   logic         clock;
   logic         reset;
   logic         csr_wen;
   logic [2:0]   csr_index;
   logic [31:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [159:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   int           fail_count;
   int           pending_count;
   int           limit_count;
   int           item_count;

   error_weighted_power_allocation dut (.*);
   error_weighted_power_allocation_check check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver stalls drawn per result, with calm stretches
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (limit_count % 400 < 60) gap = 0;
         else gap = $urandom_range(0, 11);
         rsp_tready = 1'b0;
         repeat (gap) @(negedge clock);
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_wen = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   // wait until every expected limit set has arrived, then let the pipeline drain
   task automatic drain_results();
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // one item transfer, with a random gap before it unless calm
   task automatic send_item(input logic [31:0] ea, eb, ec, ed, budget, input bit calm);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {budget, ed, ec, eb, ea};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_count++;
   endtask

   function automatic logic [31:0] random_error();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 0;
         3: return $urandom_range(0, 200000) - 100000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] random_budget();
      case ($urandom_range(0, 6))
         0: return 0;
         1: return 32'hffff_ffff;
         2: return $urandom_range(1, 4);
         3: return $urandom_range(0, 32'h0100_0000);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] cfg[5];
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      item_count = 0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, extremes and each branch
      send_item(0, 0, 0, 0, 0, 1);
      send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 1);
      send_item(32'h7fff_ffff, 32'h8000_0000, 1, 32'hffff_ffff, 32'hffff_fffe, 0);
      send_item(5, 0, 0, 0, 1, 0);
      send_item(0, 0, 0, 0, 100, 0);
      @(negedge clock);
      req_tvalid = 1'b0;
      drain_results();
      write_reg(CSR_COMP_ENABLE, 1);
      write_reg(CSR_COMP_ALPHA, 32'hffff);
      write_reg(CSR_SMALL_THRESHOLD, 32'h0001_0000);
      write_reg(CSR_RESERVE_BORDER, 32'h0010_0000);
      write_reg(CSR_RESERVE_PER_MOTOR, 32'h3fff_ffff);
      write_reg(3'd7, 32'hdead_beef);
      send_item(32'h8000, 32'h4000, 0, 0, 32'hffff_ffff, 1);
      send_item(32'h8000_0000, 7, 9, 1, 32'hffff_ffff, 0);
      send_item(3, 1, 2, 4, 1, 0);
      @(negedge clock);
      req_tvalid = 1'b0;
      drain_results();
      write_reg(CSR_COMP_ALPHA, 0);
      write_reg(CSR_RESERVE_PER_MOTOR, 32'h0000_1000);
      send_item(32'h0010_0000, 32'hfff0_0000, 5, 32'h8000_0000, 32'h0020_0000, 1);
      send_item(32'h0010_0000, 32'hfff0_0000, 5, 32'h8000_0000, 32'h0010_0000, 0);
      send_item(32'h0010_0000, 0, 0, 0, 32'h000f_ffff, 0);
      send_item(32'h0000_8000, 32'h0000_8000, 0, 0, 32'h0010_0000, 0);
      send_item(32'h0000_8001, 32'h0000_8000, 0, 0, 32'h0010_0000, 0);
      @(negedge clock);
      req_tvalid = 1'b0;
      drain_results();

      // random phases with fresh settings, extremes among them
      for (int phase = 0; phase < 12; phase++) begin
         cfg[0] = $urandom_range(0, 1);
         cfg[1] = phase == 0 ? 32'hffff : phase == 1 ? 0 : $urandom_range(0, 65535);
         cfg[2] = phase == 2 ? 32'hffff_ffff : phase == 3 ? 0 : $urandom_range(0, 32'h0040_0000);
         cfg[3] = phase == 4 ? 0 : phase == 5 ? 32'hffff_ffff : $urandom;
         cfg[4] = phase == 6 ? 32'h3fff_ffff : phase == 7 ? 0 : $urandom_range(0, 32'h0100_0000);
         for (int r = 0; r < 5; r++)
            write_reg(r[2:0], cfg[r]);
         for (int n = 0; n < 155; n++) begin
            send_item(random_error(), random_error(), random_error(), random_error(),
                      random_budget(), n % 50 < 10);
         end
         @(negedge clock);
         req_tvalid = 1'b0;
         drain_results();
      end

      $display("covered %0d items and %0d limit sets over 15 register settings",
               item_count, limit_count);
      $display("branches: zero budget, equal split, proportional and reserve split");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
